/* rtl/core/sstf_pkg.sv */
// Package: format codes and widths for the seismic sample decoder.
`default_nettype none
package sstf_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned FmtW  = 3;

    typedef enum logic [FmtW-1:0] {
        FMT_NONE0  = 3'd0,
        FMT_IBM    = 3'd1,
        FMT_INT32  = 3'd2,
        FMT_INT16  = 3'd3,
        FMT_NATIVE = 3'd4,
        FMT_IEEE   = 3'd5,
        FMT_INT8   = 3'd6,
        FMT_NONE7  = 3'd7
    } t_fmt;

    localparam t_fmt FmtReset = FMT_IBM;

    // Kind of work the normalize stages do on a word.
    typedef enum logic [1:0] {
        K_PASS = 2'd0,
        K_INT  = 2'd1,
        K_IBM  = 2'd2
    } t_kind;

    // Payload that travels down the pipe between stages.
    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [31:0] mag;    // magnitude or fraction, left to normalize
        logic [5:0]  lz;     // leading zero count found so far
        logic [9:0]  ebias;  // IBM biased exponent base (signed)
        logic [31:0] pass;   // pass-through result
    } t_stage;
endpackage
`default_nettype wire

/* rtl/core/sstf_norm.sv */
// Normalize stage: shift a magnitude left by part of its leading zero count.
`default_nettype none
module sstf_norm #(
    parameter int unsigned STEP_W = 4  // shift resolved here: at most 2**STEP_W-1 leading zeros, added to lz
) (
    input  wire  logic             i_clk,
    input  wire  logic             i_rst_n,
    input  wire  logic             i_adv,
    input  wire  logic             i_valid,
    input  wire  sstf_pkg::t_stage i_d,
    output logic                   o_valid,
    output sstf_pkg::t_stage       o_d
);
    import sstf_pkg::*;

    t_stage r_d, n_d;
    logic   r_valid;
    logic [STEP_W-1:0] w_cnt;
    logic [STEP_W:0]   w_i;
    logic              w_hit;

    // Find leading zeros among the top 2**STEP_W-1 bits, at most 2**STEP_W-1 shift
    always_comb begin
        n_d   = i_d;
        w_cnt = '0;
        w_hit = 1'b0;
        for (w_i = '0; w_i < (STEP_W+1)'((1 << STEP_W) - 1); w_i = w_i + 1'b1) begin
            if (!w_hit && !i_d.mag[31 - 32'(w_i)]) w_cnt = w_cnt + 1'b1;
            else w_hit = 1'b1;
        end
        n_d.mag = i_d.mag << w_cnt;
        n_d.lz  = i_d.lz + 6'(w_cnt);
    end

    // Advance the stage when downstream moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) r_d <= n_d;
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule
`default_nettype wire

/* rtl/core/seismic_sample_to_float_core.sv */
// Top level: seismic trace sample to IEEE-754 single decoder.
//
// Input channel: i_valid/o_stall with i_raw_sample, bytes in file
// (big-endian) order, right-aligned. Output channel: o_valid/i_stall with
// o_float_bits. Configuration: i_cfg_we writes i_cfg_data into the format
// register (1 IBM, 2 int32, 3 int16, 4 native, 5 IEEE, 6 int8); write it
// only while the pipe is empty.
// Five register stages: a decode stage, three normalize stages that each
// strip up to 15 leading zeros, and a pack and round stage. o_valid rises
// once the word has passed all five registers. One word per cycle sustains
// through the pipe while the receiver does not stall.
// Reset clears all valid bits and sets the format to IBM float.
// When the receiver stalls a valid output word, the whole pipe holds and o_stall rises, so no
// word is lost or repeated; o_stall is the output stall passed straight
// back, with the last stage acting as the output register.
`default_nettype none
module seismic_sample_to_float_core (
    input  wire  logic                       i_clk,
    input  wire  logic                       i_rst_n,
    input  wire  logic                       i_cfg_we,
    input  wire  logic [sstf_pkg::FmtW-1:0]  i_cfg_data,
    input  wire  logic                       i_valid,
    output logic                             o_stall,
    input  wire  logic [sstf_pkg::WordW-1:0] i_raw_sample,
    output logic                             o_valid,
    input  wire  logic                       i_stall,
    output logic [sstf_pkg::WordW-1:0]       o_float_bits
);
    import sstf_pkg::*;

    logic   w_adv;
    t_fmt   r_fmt;
    t_stage n_s0, r_s0;
    logic   r_v0;
    t_stage w_s1, w_s2, w_s3;
    logic   w_v1, w_v2, w_v3;
    logic [31:0] n_out, r_out;
    logic        r_vo;

    // Advance when the output register is free or being taken
    assign w_adv   = !(r_vo && i_stall);
    assign o_stall = !w_adv;

    // Hold the format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FmtReset;
        end else if (i_cfg_we) begin
            r_fmt <= t_fmt'(i_cfg_data);
        end
    end

    // Decode: sign, magnitude and kind per format
    always_comb begin
        logic [31:0] raw;
        logic [15:0] h;
        logic [7:0]  b;
        raw = i_raw_sample;
        h = raw[15:0];
        b = raw[7:0];
        n_s0 = '0;
        case (r_fmt)
            FMT_IBM: begin
                n_s0.kind  = K_IBM;
                n_s0.neg   = raw[31];
                n_s0.mag   = {raw[23:0], 8'd0};
                n_s0.ebias = {1'b0, raw[30:24], 2'b00} - 10'd130;
            end
            FMT_INT32: begin
                n_s0.kind = K_INT;
                n_s0.neg  = raw[31];
                n_s0.mag  = raw[31] ? (32'd0 - raw) : raw;
            end
            FMT_INT16: begin
                n_s0.kind = K_INT;
                n_s0.neg  = h[15];
                n_s0.mag  = {16'd0, h[15] ? (16'd0 - h) : h};
            end
            FMT_INT8: begin
                n_s0.kind = K_INT;
                n_s0.neg  = b[7];
                n_s0.mag  = {24'd0, b[7] ? (8'd0 - b) : b};
            end
            FMT_NATIVE: begin
                n_s0.pass = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            end
            FMT_IEEE: begin
                n_s0.pass = raw;
            end
            default: begin
                n_s0.pass = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_s0 <= n_s0;
    end

    // Normalize over three stages (up to 45 zeros, enough for 32)
    sstf_norm #(.STEP_W(4)) u_n1 (.i_clk, .i_rst_n, .i_adv(w_adv),
        .i_valid(r_v0), .i_d(r_s0), .o_valid(w_v1), .o_d(w_s1));
    sstf_norm #(.STEP_W(4)) u_n2 (.i_clk, .i_rst_n, .i_adv(w_adv),
        .i_valid(w_v1), .i_d(w_s1), .o_valid(w_v2), .o_d(w_s2));
    sstf_norm #(.STEP_W(4)) u_n3 (.i_clk, .i_rst_n, .i_adv(w_adv),
        .i_valid(w_v2), .i_d(w_s2), .o_valid(w_v3), .o_d(w_s3));

    // Pack: round integers, range-check IBM exponents, pass other formats through
    always_comb begin
        logic [24:0] keep;
        logic [7:0]  rem;
        logic        up;
        logic [8:0]  ex;
        logic [9:0]  e;
        keep = {1'b0, w_s3.mag[31:8]};
        rem  = w_s3.mag[7:0];
        up   = rem[7] && ((rem[6:0] != 7'd0) || keep[0]);
        ex   = 9'd158 - {3'd0, w_s3.lz};
        e    = w_s3.ebias - {4'd0, w_s3.lz};
        n_out = '0;
        case (w_s3.kind)
            K_INT: begin
                if (w_s3.mag[31]) begin
                    keep = keep + {24'd0, up};
                    if (keep[24]) begin
                        ex = ex + 9'd1;
                        keep = keep >> 1;
                    end
                    n_out = {w_s3.neg, ex[7:0], keep[22:0]};
                end
            end
            K_IBM: begin
                if (!w_s3.mag[31]) begin
                    n_out = '0;
                end else if (!e[9] && (e > 10'd254)) begin
                    n_out = {w_s3.neg, 8'hFF, 23'd0};
                end else if (e[9] || (e == 10'd0)) begin
                    n_out = '0;
                end else begin
                    n_out = {w_s3.neg, e[7:0], w_s3.mag[30:8]};
                end
            end
            default: begin
                n_out = w_s3.pass;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_adv) begin
            r_vo <= w_v3;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_out <= n_out;
    end

    assign o_valid      = r_vo;
    assign o_float_bits = r_out;

    // A stalled result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_float_bits)))
        else $error("result changed under stall");
    // Input stall follows the output side exactly
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("stall mismatch");
    // Reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule
`default_nettype wire

/* test/seismic_sample_to_float_core_tb.sv */
// Testbench for the seismic sample decoder: directed table plus random words, self-checking.
`timescale 1ns / 100ps
module seismic_sample_to_float_core_tb;
    import sstf_pkg::*;

    localparam int unsigned SettleCyc  = 10;
    localparam int unsigned HoldCyc    = 60;
    localparam int unsigned RandWords  = 1530;

    typedef struct {
        t_fmt        fmt;
        logic [31:0] raw;
        bit          typed;
        logic [31:0] want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [FmtW-1:0]   i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic [WordW-1:0]  i_raw_sample;
    logic              o_valid;
    logic              i_stall;
    logic [WordW-1:0]  o_float_bits;

    logic [31:0] float_queue[$];
    t_fmt        model_fmt;
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_trigger;
    t_row        rows[$];

    seismic_sample_to_float_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_raw_sample (i_raw_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_float_bits (o_float_bits)
    );

    // Generate the 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Convert sign and magnitude to a single, round to nearest even
    function automatic logic [31:0] int_to_float(logic neg, logic [31:0] mag);
        int          msb;
        int          sh;
        logic [31:0] keep;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] mant;
        if (mag == 32'd0) return 32'd0;
        msb = 31;
        while (mag[msb] == 1'b0) msb--;
        if (msb <= 23) begin
            mant = mag << (23 - msb);
        end else begin
            sh   = msb - 23;
            keep = mag >> sh;
            rem  = mag & ((32'd1 << sh) - 32'd1);
            half = 32'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0])) keep++;
            if (keep == 32'h0100_0000) begin
                keep = keep >> 1;
                msb++;
            end
            mant = keep;
        end
        return {neg, 8'(msb + 127), mant[22:0]};
    endfunction

    // Convert an IBM hexadecimal float word
    function automatic logic [31:0] ibm_to_float(logic [31:0] w);
        logic [23:0] frac;
        int          ex;
        frac = w[23:0];
        if (frac == 24'd0) return 32'd0;
        ex = int'(w[30:24]) * 4 - 130;
        while (frac[23] == 1'b0) begin
            frac = frac << 1;
            ex--;
        end
        if (ex > 254) return {w[31], 31'h7F80_0000};
        if (ex <= 0) return 32'd0;
        return {w[31], 8'(ex), frac[22:0]};
    endfunction

    // Predict the decoded single for one sample word
    function automatic logic [31:0] decode_sample(t_fmt fmt, logic [31:0] raw);
        case (fmt)
            FMT_IBM:    return ibm_to_float(raw);
            FMT_INT32:  return int_to_float(raw[31], raw[31] ? -raw : raw);
            FMT_INT16:  return int_to_float(raw[15], raw[15] ? 32'h1_0000 - raw[15:0]
                                                             : {16'd0, raw[15:0]});
            FMT_NATIVE: return {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            FMT_IEEE:   return raw;
            FMT_INT8:   return int_to_float(raw[7], raw[7] ? 32'h100 - raw[7:0]
                                                           : {24'd0, raw[7:0]});
            default:    return 32'd0;
        endcase
    endfunction

    // Pick a sample word that reaches the corners of each format
    function automatic logic [31:0] pick_raw();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0: w = w >> $urandom_range(0, 31);
            1: w = -(w >> $urandom_range(0, 31));
            2: w = {w[31:24], 24'd0} | (32'd1 << $urandom_range(0, 23));
            3: w = {w[31], $urandom_range(0, 1) ? 7'h7F : 7'h00, w[23:0]};
            4: w = {w[31:24], w[23:0] >> $urandom_range(0, 23)};
            default: ;
        endcase
        return w;
    endfunction

    // Stall the output side at random, with a long hold on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                hold_left = HoldCyc;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall = 1'b1;
            end else begin
                i_stall = ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Compare each accepted output word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (float_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", o_float_bits);
            end else begin
                if (o_float_bits !== float_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("float_bits mismatch: expected %h actual %h",
                                 float_queue[0], o_float_bits);
                end
                void'(float_queue.pop_front());
            end
        end
    end

    // Offer one word, holding it until accepted
    task automatic send_word(logic [31:0] raw, bit typed, logic [31:0] want);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_raw_sample = raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        float_queue.push_back(typed ? want : decode_sample(model_fmt, raw));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until the pipe has emptied
    task automatic drain_pipe();
        i_valid = 1'b0;
        while (float_queue.size() != 0) @(negedge i_clk);
        repeat (SettleCyc) @(negedge i_clk);
    endtask

    // Write the format register while idle
    task automatic write_format(t_fmt fmt);
        drain_pipe();
        i_cfg_we   = 1'b1;
        i_cfg_data = fmt;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        model_fmt  = fmt;
    endtask

    task automatic add_row(t_fmt fmt, logic [31:0] raw, bit typed, logic [31:0] want);
        rows.push_back('{fmt, raw, typed, want});
    endtask

    // Main stimulus
    initial begin
        int   phase;
        t_fmt fmt;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_raw_sample  = '0;
        model_fmt     = FmtReset;
        mismatches    = 0;
        send_idle_pct = 12;
        recv_idle_pct = 54;
        hold_trigger  = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // IBM after reset: one, zero fraction, overflow both signs, underflow; then the other formats
        add_row(FMT_IBM,    32'h4110_0000, 1, 32'h3F80_0000);
        add_row(FMT_IBM,    32'hC110_0000, 1, 32'hBF80_0000);
        add_row(FMT_IBM,    32'hFF00_0000, 1, 32'h0000_0000);
        add_row(FMT_IBM,    32'h7FFF_FFFF, 1, 32'h7F80_0000);
        add_row(FMT_IBM,    32'hFFFF_FFFF, 1, 32'hFF80_0000);
        add_row(FMT_IBM,    32'h0000_0001, 1, 32'h0000_0000);
        add_row(FMT_IBM,    32'h4100_0001, 0, 32'h0);
        add_row(FMT_IBM,    32'h2000_0001, 0, 32'h0);
        add_row(FMT_INT32,  32'h8000_0000, 1, 32'hCF00_0000);
        add_row(FMT_INT32,  32'h7FFF_FFFF, 1, 32'h4F00_0000);
        add_row(FMT_INT32,  32'h0000_0000, 1, 32'h0000_0000);
        add_row(FMT_INT32,  32'h0100_0001, 0, 32'h0);
        add_row(FMT_INT32,  32'h0100_0003, 0, 32'h0);
        add_row(FMT_INT32,  32'hFFFF_FFFF, 1, 32'hBF80_0000);
        add_row(FMT_INT16,  32'hFFFF_8000, 1, 32'hC700_0000);
        add_row(FMT_INT16,  32'h0000_7FFF, 0, 32'h0);
        add_row(FMT_INT16,  32'hABCD_0001, 1, 32'h3F80_0000);
        add_row(FMT_NATIVE, 32'h1234_5678, 1, 32'h7856_3412);
        add_row(FMT_IEEE,   32'hDEAD_BEEF, 1, 32'hDEAD_BEEF);
        add_row(FMT_INT8,   32'hFFFF_FF80, 1, 32'hC300_0000);
        add_row(FMT_INT8,   32'h1234_567F, 0, 32'h0);
        add_row(FMT_NONE0,  32'hFFFF_FFFF, 1, 32'h0000_0000);
        add_row(FMT_NONE7,  32'h4110_0000, 1, 32'h0000_0000);

        // Walk the directed table
        foreach (rows[i]) begin
            if (rows[i].fmt != model_fmt) write_format(rows[i].fmt);
            send_word(rows[i].raw, rows[i].typed, rows[i].want);
        end

        // Random words in three idling phases, format changed every block
        for (int n = 0; n < RandWords; n++) begin
            phase = n * 3 / RandWords;
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 12 : 0;
            if (n % 90 == 0) begin
                fmt = t_fmt'($urandom_range(0, 19) < 2 ? $urandom_range(0, 7)
                                                        : $urandom_range(1, 6));
                write_format(fmt);
            end
            // Hold the receiver off while the sender keeps pushing
            if (n == RandWords - 200) hold_trigger++;
            send_word(pick_raw(), 0, 32'h0);
        end

        drain_pipe();
        if (mismatches == 0 && float_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

/* seismic_sample_to_float_core.f */
rtl/core/sstf_pkg.sv
rtl/core/sstf_norm.sv
rtl/core/seismic_sample_to_float_core.sv
test/seismic_sample_to_float_core_tb.sv
